>>> design/lpt_pkg.sv
// ----------------------------------------------------------------------------
// lpt_pkg: shared types and constants for the LRU page tracker
// Frame count, page width and the word types passed between modules.
// ----------------------------------------------------------------------------
package lpt_pkg;

  localparam int FRAMES       = 16;
  localparam int PAGE_BITS    = 16;
  localparam int PAGE_FIELD_W = 16;
  localparam int CAP_W        = 5;
  localparam int FAULT_W      = 16;

  localparam int PAGE_W  = (PAGE_BITS < PAGE_FIELD_W) ? PAGE_BITS : PAGE_FIELD_W;
  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int COUNT_W = $clog2(FRAMES + 1);

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              last;
  } lpt_req_t;

  typedef struct packed {
    logic                    hit;
    logic                    evicted_valid;
    logic [PAGE_FIELD_W-1:0] evicted_page;
  } lpt_result_t;

endpackage

>>> design/lpt_stack.sv
// ----------------------------------------------------------------------------
// lpt_stack: recency stack with parallel lookup and registered update
// Compares a page against all resident frames, reports hit or eviction and
// shifts the stack so the referenced page lands on top.
// ----------------------------------------------------------------------------
module lpt_stack (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  lpt_pkg::lpt_req_t             req,
  input  logic [lpt_pkg::COUNT_W-1:0]   cap_eff,
  output lpt_pkg::lpt_result_t          result,
  output logic [lpt_pkg::COUNT_W-1:0]   frames_used
);

  logic [lpt_pkg::PAGE_W-1:0]  stack [lpt_pkg::FRAMES];
  logic [lpt_pkg::FRAMES-1:0]  match;
  logic [lpt_pkg::FRAMES-1:0]  shift_en;
  logic                        hit;
  logic                        evict;
  logic [lpt_pkg::COUNT_W-1:0] last_idx;
  logic [lpt_pkg::COUNT_W-1:0] fu_after;
  logic [lpt_pkg::COUNT_W-1:0] frames_used_next;

  always_comb begin
    for (int i = 0; i < lpt_pkg::FRAMES; i++) begin
      match[i] = (lpt_pkg::COUNT_W'(i) < frames_used) && (stack[i] == req.page);
    end
    hit      = |match;
    evict    = !hit && (frames_used >= cap_eff) && (frames_used != '0);
    last_idx = frames_used - lpt_pkg::COUNT_W'(1);
    fu_after = evict ? last_idx : frames_used;

    shift_en = '0;
    for (int k = 1; k < lpt_pkg::FRAMES; k++) begin
      if (hit) begin
        for (int j = 0; j < lpt_pkg::FRAMES; j++) begin
          if (j >= k && match[j]) begin
            shift_en[k] = 1'b1;
          end
        end
      end else begin
        shift_en[k] = (lpt_pkg::COUNT_W'(k) <= fu_after);
      end
    end

    if (hit) begin
      frames_used_next = frames_used;
    end else if (fu_after < lpt_pkg::COUNT_W'(lpt_pkg::FRAMES)) begin
      frames_used_next = fu_after + lpt_pkg::COUNT_W'(1);
    end else begin
      frames_used_next = fu_after;
    end

    result.hit           = hit;
    result.evicted_valid = evict;
    result.evicted_page  = evict ?
      lpt_pkg::PAGE_FIELD_W'(stack[last_idx[lpt_pkg::IDX_W-1:0]]) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_used <= '0;
    end else if (step) begin
      frames_used <= req.last ? '0 : frames_used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      stack[0] <= req.page;
      for (int k = 1; k < lpt_pkg::FRAMES; k++) begin
        if (shift_en[k]) begin
          stack[k] <= stack[k-1];
        end
      end
    end
  end

endmodule

>>> design/lru_page_tracker.sv
// ----------------------------------------------------------------------------
// lru_page_tracker: fully associative LRU page-frame tracker
// Pipeline: input register, then result register; a stalled output holds
// both. Throughput: one word per cycle while the output is not stalled; the
// lookup and stack shift are done between the two registers.
// Reset: empties the table, zeroes the fault count, capacity returns to 16.
// ----------------------------------------------------------------------------
module lru_page_tracker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lpt_pkg::PAGE_FIELD_W-1:0] page_number,
  input  logic                            last_of_run,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic                            evicted_valid,
  output logic [lpt_pkg::PAGE_FIELD_W-1:0] evicted_page,
  output logic [lpt_pkg::FAULT_W-1:0]     fault_total,
  input  logic                            cfg_wr_en,
  input  logic [lpt_pkg::CAP_W-1:0]       cfg_wr_data
);

  logic [lpt_pkg::CAP_W-1:0]   capacity;
  logic [lpt_pkg::COUNT_W-1:0] cap_eff;
  logic                        req_valid;
  lpt_pkg::lpt_req_t           req;
  logic                        step;
  lpt_pkg::lpt_result_t        result;
  logic [lpt_pkg::COUNT_W-1:0] frames_used;
  logic [lpt_pkg::FAULT_W-1:0] fault_count;
  logic [lpt_pkg::FAULT_W-1:0] fault_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lpt_pkg::CAP_W'(16);
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  always_comb begin
    if (capacity == '0) begin
      cap_eff = lpt_pkg::COUNT_W'(1);
    end else if (int'(capacity) > lpt_pkg::FRAMES) begin
      cap_eff = lpt_pkg::COUNT_W'(lpt_pkg::FRAMES);
    end else begin
      cap_eff = lpt_pkg::COUNT_W'(capacity);
    end
  end

  assign step     = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req.page <= page_number[lpt_pkg::PAGE_W-1:0];
      req.last <= last_of_run;
    end
  end

  lpt_stack u_stack (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .req         (req),
    .cap_eff     (cap_eff),
    .result      (result),
    .frames_used (frames_used)
  );

  always_comb begin
    if (!result.hit && fault_count != '1) begin
      fault_count_next = fault_count + lpt_pkg::FAULT_W'(1);
    end else begin
      fault_count_next = fault_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_count <= '0;
    end else if (step) begin
      fault_count <= req.last ? '0 : fault_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hit           <= result.hit;
      evicted_valid <= result.evicted_valid;
      evicted_page  <= result.evicted_page;
      fault_total   <= fault_count_next;
    end
  end

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted_valid))
    else $error("hit and eviction reported together");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !evicted_valid) |-> (evicted_page == '0))
    else $error("evicted page nonzero without eviction");

  a_frames_bound: assert property (@(posedge clk) disable iff (rst)
    int'(frames_used) <= lpt_pkg::FRAMES)
    else $error("frames in use exceed frame count");

  a_hit_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (step && result.hit && !req.last) |=> (fault_count == $past(fault_count)))
    else $error("fault count changed on a hit");

endmodule

>>> test/tb_lru_page_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_tracker: self-checking bench for the LRU page-frame tracker
// Feeds page references through the valid/ready input channel under random
// idle bursts and a long output stall. A local LRU stack predicts hit, eviction
// and fault count per reference, and every result word is checked in order.
// Covers capacity extremes, capacity lowered mid-run, last-of-run clears and
// a back-to-back tail of misses.
// ----------------------------------------------------------------------------
module tb_lru_page_tracker;

  localparam int LIMIT      = 600000;
  localparam int PHASES     = 7;
  localparam int PHASE_REFS = 76;
  localparam int TAIL_REFS  = 40;
  localparam int CAP_PLAN [PHASES] = '{16, 1, 0, 31, 17, 4, 9};
  localparam int ODDS_PLAN[PHASES] = '{4, 8, 3, 0, 6, 8, 5};

  typedef struct packed {
    logic [lpt_pkg::PAGE_FIELD_W-1:0] page;
    logic                             last;
  } page_ref_t;

  typedef struct packed {
    logic                             hit;
    logic                             evicted_valid;
    logic [lpt_pkg::PAGE_FIELD_W-1:0] evicted_page;
    logic [lpt_pkg::FAULT_W-1:0]      faults;
  } page_outcome_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [lpt_pkg::PAGE_FIELD_W-1:0] page_number = '0;
  logic                             last_of_run = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             hit;
  logic                             evicted_valid;
  logic [lpt_pkg::PAGE_FIELD_W-1:0] evicted_page;
  logic [lpt_pkg::FAULT_W-1:0]      fault_total;
  logic                             cfg_wr_en = 1'b0;
  logic [lpt_pkg::CAP_W-1:0]        cfg_wr_data = '0;

  page_ref_t     page_refs[$];
  page_outcome_t awaited_outcomes[$];

  // predictor state
  logic [lpt_pkg::PAGE_W-1:0]  lru_stack[lpt_pkg::FRAMES];
  int                          frames_held = 0;
  logic [lpt_pkg::FAULT_W-1:0] fault_tally = '0;
  logic [lpt_pkg::CAP_W-1:0]   cap_reg = 5'd16;

  int  idle_odds = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  logic long_hold = 1'b0;
  int  queued = 0;
  int  accepted = 0;
  int  checked = 0;
  int  errors = 0;
  int  hits_seen = 0;
  int  evictions_seen = 0;
  int  cap_writes = 0;
  int  cycle_cnt = 0;

  lru_page_tracker dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .page_number  (page_number),
    .last_of_run  (last_of_run),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .evicted_valid(evicted_valid),
    .evicted_page (evicted_page),
    .fault_total  (fault_total),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic page_outcome_t lru_lookup(
    input logic [lpt_pkg::PAGE_FIELD_W-1:0] ref_page,
    input logic                             last
  );
    page_outcome_t              r;
    logic [lpt_pkg::PAGE_W-1:0] page;
    int                         lim;
    int                         pos;
    r    = '0;
    pos  = 0;
    page = ref_page[lpt_pkg::PAGE_W-1:0];
    lim  = (cap_reg == 0) ? 1 : int'(cap_reg);
    if (lim > lpt_pkg::FRAMES) lim = lpt_pkg::FRAMES;
    for (int i = 0; i < frames_held; i++) begin
      if (!r.hit && lru_stack[i] == page) begin
        r.hit = 1'b1;
        pos   = i;
      end
    end
    if (r.hit) begin
      for (int k = pos; k > 0; k--) lru_stack[k] = lru_stack[k-1];
      lru_stack[0] = page;
    end else begin
      if (fault_tally != '1) fault_tally++;
      if (frames_held >= lim && frames_held > 0) begin
        r.evicted_valid = 1'b1;
        r.evicted_page  = lpt_pkg::PAGE_FIELD_W'(lru_stack[frames_held-1]);
        frames_held--;
      end
      for (int k = frames_held; k > 0; k--) begin
        if (k < lpt_pkg::FRAMES) lru_stack[k] = lru_stack[k-1];
      end
      lru_stack[0] = page;
      if (frames_held < lpt_pkg::FRAMES) frames_held++;
    end
    r.faults = fault_tally;
    if (last) begin
      frames_held = 0;
      fault_tally = '0;
    end
    return r;
  endfunction

  // sender: hold until accepted, then advance or idle
  always @(posedge clk) begin
    page_ref_t w;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (page_refs.size() > 0) begin
        w = page_refs[0];
        page_refs.delete(0);
        in_valid    <= 1'b1;
        page_number <= w.page;
        last_of_run <= w.last;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
          send_gap = $urandom_range(1, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // predict on every accepted word
  always @(posedge clk) begin
    page_outcome_t e;
    if (!rst && in_valid && in_ready) begin
      e = lru_lookup(page_number, last_of_run);
      if (e.hit) hits_seen++;
      if (e.evicted_valid) evictions_seen++;
      awaited_outcomes.insert(awaited_outcomes.size(), e);
      accepted++;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else if (long_hold) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      recv_gap = $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // check result words in order
  always @(posedge clk) begin
    page_outcome_t e;
    if (!rst && out_valid && out_ready) begin
      if (awaited_outcomes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: hit=%0b ev=%0b page=%h faults=%0d",
                   hit, evicted_valid, evicted_page, fault_total);
      end else begin
        e = awaited_outcomes[0];
        awaited_outcomes.delete(0);
        checked++;
        if (hit !== e.hit || evicted_valid !== e.evicted_valid ||
            evicted_page !== e.evicted_page || fault_total !== e.faults) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch on word %0d: expected hit=%0b ev=%0b page=%h ",
                      "faults=%0d, got hit=%0b ev=%0b page=%h faults=%0d"},
                     checked, e.hit, e.evicted_valid, e.evicted_page, e.faults,
                     hit, evicted_valid, evicted_page, fault_total);
        end
      end
    end
  end

  // long output stall while the sender keeps offering
  initial begin
    wait (accepted >= 80);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (300) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic queue_ref(input logic [lpt_pkg::PAGE_FIELD_W-1:0] p, input logic l);
    page_ref_t w;
    w.page = p;
    w.last = l;
    page_refs.insert(page_refs.size(), w);
    queued++;
  endtask

  task automatic drain();
    while (checked < queued)
      @(posedge clk);
  endtask

  task automatic set_capacity(input logic [lpt_pkg::CAP_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    cap_reg = v;
    cap_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [lpt_pkg::PAGE_FIELD_W-1:0] base;
    logic [lpt_pkg::CAP_W-1:0]        cap_next;
    int                               ws;
    int                               eff;
    wait (!rst);
    @(posedge clk);

    // reset capacity: fill all frames, then evict and hit deep
    idle_odds = 4;
    queue_ref(16'h0000, 1'b0);
    queue_ref(16'hFFFF, 1'b0);
    queue_ref(16'h0000, 1'b0);
    queue_ref(16'hFFFF, 1'b0);
    for (int i = 1; i <= 14; i++) queue_ref(lpt_pkg::PAGE_FIELD_W'(i), 1'b0);
    queue_ref(16'h1234, 1'b0);
    queue_ref(16'hFFFF, 1'b0);
    drain();

    // capacity lowered below occupancy, then a clear
    set_capacity(5'd2);
    queue_ref(16'h8000, 1'b0);
    queue_ref(16'h0005, 1'b0);
    queue_ref(16'h4000, 1'b1);
    queue_ref(16'h8000, 1'b0);
    queue_ref(16'h7FFF, 1'b0);
    queue_ref(16'h0001, 1'b0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      cap_next = (p == PHASES - 1) ? lpt_pkg::CAP_W'($urandom_range(0, 31))
                                   : lpt_pkg::CAP_W'(CAP_PLAN[p]);
      set_capacity(cap_next);
      idle_odds = ODDS_PLAN[p];
      eff = (cap_next == 0) ? 1 :
            ((cap_next > lpt_pkg::FRAMES) ? lpt_pkg::FRAMES : int'(cap_next));
      ws = eff + $urandom_range(1, 4);
      base = lpt_pkg::PAGE_FIELD_W'($urandom);
      for (int i = 0; i < PHASE_REFS; i++) begin
        if ($urandom_range(0, 99) < 75)
          queue_ref(base + lpt_pkg::PAGE_FIELD_W'($urandom_range(0, ws - 1)),
                    $urandom_range(0, 39) == 0);
        else
          queue_ref(lpt_pkg::PAGE_FIELD_W'($urandom), $urandom_range(0, 39) == 0);
      end
      drain();
    end

    // back-to-back misses with no idling, then clear
    set_capacity(5'd1);
    idle_odds = 0;
    for (int i = 0; i < TAIL_REFS; i++)
      queue_ref(i[0] ? 16'h5500 : 16'h00AA, 1'b0);
    queue_ref(16'hA5A5, 1'b1);
    queue_ref(16'h00AA, 1'b0);
    drain();

    repeat (8) @(posedge clk);
    $display("Checked %0d of %0d references (%0d hits, %0d evictions) over %0d %s",
             checked, accepted, hits_seen, evictions_seen, cap_writes,
             "capacity writes,");
    $display("including a long output stall, mid-run capacity drops and a gapless tail.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
